>>> rtl/hafcs_pkg.sv
// Shared constants, command type and CRC helper for the async HDLC framer.
package hafcs_pkg;

    localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
    localparam logic [7:0]  ESC_BYTE   = 8'h7D;
    localparam logic [7:0]  XOR_MASK   = 8'h20;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam int          CMDQ_DEPTH = 4;

    typedef struct packed {
        logic        open;
        logic        has_data;
        logic        close;
        logic [7:0]  data;
        logic [15:0] fcs;
    } cmd_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

>>> rtl/hdlc_async_framer_fcs16.sv
// Top level of the asynchronous HDLC framer with FCS-16.
// Payload bytes enter through a push/full queue port and framed line bytes leave
// through an empty/pop queue port, one line byte per clock at most. Each input
// transaction produces 1 to 8 line bytes (opening flag, data with escape, FCS with
// escape, closing flag); run_last marks the final byte of each transaction. The
// line side sets the rate: a transaction holds the byte sequencer until all of its
// bytes have been produced, typically 1 to 2 for plain payload. The CRC update
// and command build happen in the cycle of acceptance, and a command queue of
// CMDQ_DEPTH entries lets input transactions be taken while the sequencer is busy.
module hdlc_async_framer_fcs16
#(
    parameter int CMDQ_DEPTH = hafcs_pkg::CMDQ_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data,
    input  logic       frame_end,
    input  logic       close_only,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] line_byte,
    output logic       run_last
);

    hafcs_pkg::cmd_t wr_cmd;
    hafcs_pkg::cmd_t rd_cmd;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;

    hafcs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data       (data),
        .frame_end  (frame_end),
        .close_only (close_only),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (wr_cmd)
    );

    hafcs_cmdq #(.DEPTH(CMDQ_DEPTH)) u_cmdq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_cmd (wr_cmd),
        .full   (q_full),
        .pop    (q_pop),
        .rd_cmd (rd_cmd),
        .empty  (q_empty)
    );

    hafcs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_cmd     (rd_cmd),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .line_byte (line_byte),
        .run_last  (run_last)
    );

endmodule

>>> rtl/hafcs_front.sv
// Front end: accepts input transactions, tracks frame state and CRC, issues commands.
module hafcs_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         data,
    input  logic               frame_end,
    input  logic               close_only,
    input  logic               q_full,
    output logic               q_push,
    output hafcs_pkg::cmd_t    q_cmd
);

    logic        in_frame_reg;
    logic        in_frame_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] crc_upd;
    logic        accept;
    logic        closing;

    assign full    = q_full;
    assign accept  = push && !q_full;
    assign q_push  = accept;
    assign closing = close_only || frame_end;
    assign crc_upd = close_only ? crc_reg : hafcs_pkg::crc_byte(crc_reg, data);

    always_comb
    begin
        q_cmd.open     = !in_frame_reg;
        q_cmd.has_data = !close_only;
        q_cmd.close    = closing;
        q_cmd.data     = data;
        q_cmd.fcs      = ~crc_upd;
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        crc_next      = crc_reg;
        if (accept)
        begin
            if (closing)
            begin
                in_frame_next = 1'b0;
                crc_next      = hafcs_pkg::CRC_INIT;
            end
            else
            begin
                in_frame_next = 1'b1;
                crc_next      = crc_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            crc_reg      <= hafcs_pkg::CRC_INIT;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            crc_reg      <= crc_next;
        end
    end

    a_close_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && closing |=> !in_frame_reg && crc_reg == hafcs_pkg::CRC_INIT)
        else $error("frame close did not reset CRC and frame state");

endmodule

>>> rtl/hafcs_cmdq.sv
// Short command queue between the front end and the byte sequencer.
module hafcs_cmdq
#(
    parameter int DEPTH = hafcs_pkg::CMDQ_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hafcs_pkg::cmd_t    wr_cmd,
    output logic               full,
    input  logic               pop,
    output hafcs_pkg::cmd_t    rd_cmd,
    output logic               empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hafcs_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_cmd  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_cmd;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("command queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("command pushed into full queue");

endmodule

>>> rtl/hafcs_back.sv
// Back end: sequences flag, escaped data and FCS bytes into the output register.
module hafcs_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  hafcs_pkg::cmd_t    q_cmd,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         line_byte,
    output logic               run_last
);

    localparam logic [2:0] PH_OPEN  = 3'd0;
    localparam logic [2:0] PH_DATA  = 3'd1;
    localparam logic [2:0] PH_FCSL  = 3'd2;
    localparam logic [2:0] PH_FCSH  = 3'd3;
    localparam logic [2:0] PH_CLOSE = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;

    hafcs_pkg::cmd_t cur_reg;
    hafcs_pkg::cmd_t cur_next;
    logic            cur_valid_reg;
    logic            cur_valid_next;
    logic [2:0]      phase_reg;
    logic [2:0]      phase_next;
    logic            esc_reg;
    logic            esc_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [7:0]      out_byte_reg;
    logic [7:0]      out_byte_next;
    logic            out_last_reg;
    logic            out_last_next;

    logic            out_free;
    logic            step;
    logic            escapable;
    logic [7:0]      src;
    logic            need_esc;
    logic            advance;
    logic [2:0]      adv_phase;
    logic            last;
    logic            load;
    logic [2:0]      start_phase;

    assign empty     = !out_valid_reg;
    assign line_byte = out_byte_reg;
    assign run_last  = out_last_reg;
    assign out_free  = !out_valid_reg || pop;
    assign step      = cur_valid_reg && out_free;

    always_comb
    begin
        unique case (phase_reg)
            PH_DATA:
            begin
                escapable = 1'b1;
                src       = cur_reg.data;
            end
            PH_FCSL:
            begin
                escapable = 1'b1;
                src       = cur_reg.fcs[7:0];
            end
            PH_FCSH:
            begin
                escapable = 1'b1;
                src       = cur_reg.fcs[15:8];
            end
            default:
            begin
                escapable = 1'b0;
                src       = hafcs_pkg::FLAG_BYTE;
            end
        endcase
    end

    assign need_esc = (src < hafcs_pkg::XOR_MASK) || (src == hafcs_pkg::ESC_BYTE)
                      || (src == hafcs_pkg::FLAG_BYTE);

    always_comb
    begin
        unique case (phase_reg)
            PH_OPEN:  adv_phase = cur_reg.has_data ? PH_DATA : PH_FCSL;
            PH_DATA:  adv_phase = cur_reg.close ? PH_FCSL : PH_DONE;
            PH_FCSL:  adv_phase = PH_FCSH;
            PH_FCSH:  adv_phase = PH_CLOSE;
            default:  adv_phase = PH_DONE;
        endcase
    end

    assign advance = !(escapable && need_esc && !esc_reg);
    assign last    = advance && (adv_phase == PH_DONE);
    assign load    = (!cur_valid_reg || (step && last)) && !q_empty;
    assign q_pop   = load;

    assign start_phase = q_cmd.open ? PH_OPEN : (q_cmd.has_data ? PH_DATA : PH_FCSL);

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        phase_next     = phase_reg;
        esc_next       = esc_reg;
        out_valid_next = out_valid_reg && !pop;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (step)
        begin
            out_valid_next = 1'b1;
            out_last_next  = last;
            if (!advance)
            begin
                out_byte_next = hafcs_pkg::ESC_BYTE;
                esc_next      = 1'b1;
            end
            else
            begin
                out_byte_next = esc_reg ? (src ^ hafcs_pkg::XOR_MASK) : src;
                esc_next      = 1'b0;
                phase_next    = adv_phase;
                if (last)
                    cur_valid_next = 1'b0;
            end
        end

        if (load)
        begin
            cur_next       = q_cmd;
            cur_valid_next = 1'b1;
            phase_next     = start_phase;
            esc_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= PH_OPEN;
            esc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            phase_reg     <= phase_next;
            esc_reg       <= esc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    a_esc_phase: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> (phase_reg == PH_DATA || phase_reg == PH_FCSL || phase_reg == PH_FCSH))
        else $error("escape pending outside an escapable byte");

    a_fcs_needs_close: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && (phase_reg == PH_FCSL || phase_reg == PH_FCSH
                          || phase_reg == PH_CLOSE) |-> cur_reg.close)
        else $error("FCS or closing flag sent for a command that does not close");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the async HDLC framer with FCS-16.
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic [7:0] line_byte;
        logic       run_last;
    } line_out_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] data;
    logic       frame_end;
    logic       close_only;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] line_byte;
    logic       run_last;

    line_out_t   framed_q[$];
    logic        frame_open;
    logic [15:0] fcs_acc;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          fail_count;
    int          items_taken;
    int          lines_checked;
    int          frames_closed;

    hdlc_async_framer_fcs16 uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data       (data),
        .frame_end  (frame_end),
        .close_only (close_only),
        .empty      (empty),
        .pop        (pop),
        .line_byte  (line_byte),
        .run_last   (run_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Reflected CRC-16, one input bit at a time.
    function automatic logic [15:0] fcs_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c = c >> 1;
            if (fb)
                c = c ^ hafcs_pkg::CRC_POLY;
        end
        return c;
    endfunction

    function automatic void put_line(input logic [7:0] b, input logic last);
        line_out_t e;
        e.line_byte = b;
        e.run_last  = last;
        framed_q.push_back(e);
    endfunction

    function automatic void put_escaped(input logic [7:0] b, input logic last);
        if (b < hafcs_pkg::XOR_MASK || b == hafcs_pkg::ESC_BYTE || b == hafcs_pkg::FLAG_BYTE)
        begin
            put_line(hafcs_pkg::ESC_BYTE, 1'b0);
            put_line(b ^ hafcs_pkg::XOR_MASK, last);
        end
        else
        begin
            put_line(b, last);
        end
    endfunction

    function automatic void frame_transaction(input logic [7:0] d, input logic fe,
                                              input logic co);
        logic [15:0] fcs;
        if (!frame_open)
        begin
            put_line(hafcs_pkg::FLAG_BYTE, 1'b0);
            frame_open = 1'b1;
        end
        if (!co)
        begin
            put_escaped(d, !fe);
            fcs_acc = fcs_update(fcs_acc, d);
        end
        if (co || fe)
        begin
            fcs = ~fcs_acc;
            put_escaped(fcs[7:0], 1'b0);
            put_escaped(fcs[15:8], 1'b0);
            put_line(hafcs_pkg::FLAG_BYTE, 1'b1);
            frame_open = 1'b0;
            fcs_acc = hafcs_pkg::CRC_INIT;
            frames_closed++;
        end
    endfunction

    // Prediction on accepted input, compare on accepted output.
    always @(posedge clk)
    begin
        line_out_t e;
        if (rst_n)
        begin
            if (push && !full)
            begin
                frame_transaction(data, frame_end, close_only);
                items_taken++;
            end
            if (pop && !empty)
            begin
                lines_checked++;
                if (framed_q.size() == 0)
                begin
                    $error("unexpected line_byte %02h run_last %0d", line_byte, run_last);
                    fail_count++;
                end
                else
                begin
                    e = framed_q.pop_front();
                    if (line_byte !== e.line_byte)
                    begin
                        $error("line_byte: expected %02h, got %02h", e.line_byte, line_byte);
                        fail_count++;
                    end
                    if (run_last !== e.run_last)
                    begin
                        $error("run_last: expected %0d, got %0d", e.run_last, run_last);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    task automatic send_item(input logic [7:0] d, input logic fe, input logic co);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        data       <= d;
        frame_end  <= fe;
        close_only <= co;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        push <= 1'b0;
        while (framed_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return hafcs_pkg::FLAG_BYTE;
            1: return hafcs_pkg::ESC_BYTE;
            2: return 8'($urandom_range(31));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic test_close_cases();
        send_item(8'hA5, 1'b0, 1'b1);   // close while idle: empty frame
        send_item(8'h3C, 1'b1, 1'b1);   // close with frame_end set, data unused
        send_item(8'h80, 1'b0, 1'b0);
        send_item(8'hAA, 1'b1, 1'b1);   // close_only ends an open frame
        send_item(8'h55, 1'b1, 1'b0);   // one-byte frame
    endtask

    task automatic test_escapes();
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h1F, 1'b0, 1'b0);
        send_item(8'h20, 1'b0, 1'b0);
        send_item(hafcs_pkg::ESC_BYTE, 1'b0, 1'b0);
        send_item(hafcs_pkg::FLAG_BYTE, 1'b0, 1'b0);
        send_item(8'h7F, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
    endtask

    // "123456789" has the well-known FCS 0x906E.
    task automatic test_known_fcs();
        for (int i = 0; i < 9; i++)
            send_item(8'h31 + 8'(i), 1'(i == 8), 1'b0);
    endtask

    task automatic test_long_frame();
        for (int i = 0; i < 40; i++)
            send_item(pick_byte(), 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_random(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) < 8)
            begin
                len = $urandom_range(6);
                if (len == 0)
                    send_item(pick_byte(), 1'($urandom_range(1)), 1'b1);
                for (int k = 0; k < len; k++)
                    send_item(pick_byte(), 1'(k == len - 1), 1'b0);
                sent += (len == 0) ? 1 : len;
            end
            else
            begin
                send_item(8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(9) == 0));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        push          = 1'b0;
        data          = 8'h00;
        frame_end     = 1'b0;
        close_only    = 1'b0;
        frame_open    = 1'b0;
        fcs_acc       = hafcs_pkg::CRC_INIT;
        fail_count    = 0;
        items_taken   = 0;
        lines_checked = 0;
        frames_closed = 0;
        send_idle_pct = 26;
        recv_idle_pct = 80;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_close_cases();
        test_escapes();
        test_known_fcs();
        test_random(12);
        wait_drain();

        send_idle_pct = 80;
        recv_idle_pct = 26;
        test_long_frame();
        test_random(12);
        wait_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(12);
        send_item(8'h00, 1'b0, 1'b1);
        wait_drain();

        $display("covered %0d input transactions, %0d line bytes, %0d frames closed",
                 items_taken, lines_checked, frames_closed);
        $display("escapes, empty frames, open frames and three idle profiles exercised");
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
